// File: hw/rtl/tfk_pkg.sv
// Shared types, constants and helper functions for the tripod kinematics pipeline.
`default_nettype none

package tfk_pkg;

    localparam int DIV_STEPS  = 32;
    localparam int SQRT_STEPS = 32;
    localparam int NUM_W      = 72;

    localparam logic [1:0] CFG_BX = 2'd0;
    localparam logic [1:0] CFG_CX = 2'd1;
    localparam logic [1:0] CFG_CY = 2'd2;

    localparam logic [31:0] CFG_RESET = 32'h0001_0000;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_B_ORIGIN  = 2'd1,
        ST_COLLINEAR = 2'd2,
        ST_UNREACH   = 2'd3
    } tfk_status_t;

    typedef struct packed {
        logic [31:0]        ad;
        logic               below;
        logic [63:0]        ad2;
        logic signed [66:0] mpart;
        logic signed [32:0] x;
        logic [31:0]        ym;
        logic               yneg;
        logic               fail;
    } tfk_side_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [32:0] abs2x(input logic [31:0] v);
        abs2x = {mag32(v), 1'b0};
    endfunction

    function automatic logic [31:0] sat33(input logic [32:0] v);
        if (v[32] != v[31])
        begin
            sat33 = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            sat33 = v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tfk_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none

module tfk_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       in_valid,
    input  wire logic [tfk_pkg::NUM_W-1:0]  in_num,
    input  wire logic                       in_neg,
    input  wire logic [32:0]                in_den,
    input  wire tfk_pkg::tfk_side_t         in_side,
    output logic                            out_valid,
    output logic [31:0]                     out_quo,
    output logic                            out_neg,
    output logic                            out_ovf,
    output tfk_pkg::tfk_side_t              out_side
);

    logic [32:0]        rem_reg  [0:tfk_pkg::DIV_STEPS];
    logic [31:0]        low_reg  [0:tfk_pkg::DIV_STEPS];
    logic [31:0]        quo_reg  [0:tfk_pkg::DIV_STEPS];
    logic [32:0]        den_reg  [0:tfk_pkg::DIV_STEPS];
    logic               neg_reg  [0:tfk_pkg::DIV_STEPS];
    logic               ovf_reg  [0:tfk_pkg::DIV_STEPS];
    tfk_pkg::tfk_side_t side_reg [0:tfk_pkg::DIV_STEPS];
    logic               v_reg    [0:tfk_pkg::DIV_STEPS];

    logic ovf_next;

    // A quotient of 2^32 or more shows up as a high part not below the divisor.
    assign ovf_next = (in_num[tfk_pkg::NUM_W-1:32] >= {{(tfk_pkg::NUM_W-65){1'b0}}, in_den});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= in_num[64:32];
            low_reg[0]  <= in_num[31:0];
            quo_reg[0]  <= 32'd0;
            den_reg[0]  <= in_den;
            neg_reg[0]  <= in_neg;
            ovf_reg[0]  <= ovf_next;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < tfk_pkg::DIV_STEPS; k++)
    begin : g_step
        logic [33:0] trial;
        logic        ge;

        assign trial = {rem_reg[k], low_reg[k][31]};
        assign ge    = (trial >= {1'b0, den_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1]  <= ge ? 33'(trial - {1'b0, den_reg[k]}) : trial[32:0];
                low_reg[k+1]  <= {low_reg[k][30:0], 1'b0};
                quo_reg[k+1]  <= {quo_reg[k][30:0], ge};
                den_reg[k+1]  <= den_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[tfk_pkg::DIV_STEPS];
    assign out_quo   = quo_reg[tfk_pkg::DIV_STEPS];
    assign out_neg   = neg_reg[tfk_pkg::DIV_STEPS];
    assign out_ovf   = ovf_reg[tfk_pkg::DIV_STEPS];
    assign out_side  = side_reg[tfk_pkg::DIV_STEPS];

endmodule

`default_nettype wire

// File: hw/rtl/tfk_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
`default_nettype none

module tfk_sqrt (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               in_valid,
    input  wire logic [63:0]        in_rad,
    input  wire tfk_pkg::tfk_side_t in_side,
    output logic                    out_valid,
    output logic [31:0]             out_root,
    output tfk_pkg::tfk_side_t      out_side
);

    logic [32:0]        rem_reg  [0:tfk_pkg::SQRT_STEPS];
    logic [63:0]        dat_reg  [0:tfk_pkg::SQRT_STEPS];
    logic [31:0]        root_reg [0:tfk_pkg::SQRT_STEPS];
    tfk_pkg::tfk_side_t side_reg [0:tfk_pkg::SQRT_STEPS];
    logic               v_reg    [0:tfk_pkg::SQRT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= 33'd0;
            dat_reg[0]  <= in_rad;
            root_reg[0] <= 32'd0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < tfk_pkg::SQRT_STEPS; k++)
    begin : g_step
        logic [34:0] cur;
        logic [33:0] trial;
        logic        ge;

        assign cur   = {rem_reg[k], dat_reg[k][63:62]};
        assign trial = {root_reg[k], 2'b01};
        assign ge    = (cur >= {1'b0, trial});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1]  <= ge ? 33'(cur - {1'b0, trial}) : cur[32:0];
                dat_reg[k+1]  <= {dat_reg[k][61:0], 2'b00};
                root_reg[k+1] <= {root_reg[k][30:0], ge};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[tfk_pkg::SQRT_STEPS];
    assign out_root  = root_reg[tfk_pkg::SQRT_STEPS];
    assign out_side  = side_reg[tfk_pkg::SQRT_STEPS];

endmodule

`default_nettype wire

// File: hw/rtl/tripod_forward_kinematics.sv
// Top level of the tripod forward kinematics pipeline (trilateration to x, y, z).
//
// Channel  Direction  Handshake              Beat contents
// cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_data
// in       in         in_valid/in_ready      strut_ad, strut_bd, strut_cd, below
// out      out        out_valid/out_ready    pos_x, pos_y, pos_z, status
//
// One beat enters per cycle unless the output is stalled.
// The pipeline holds two 33-stage dividers and a 33-stage square root.
// Reset clears the valid bits and loads 1.0 into the three base registers.
// A stall on the output holds every stage in place; cfg_ready is always high.
`default_nettype none

module tripod_forward_kinematics (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] strut_ad,
    input  wire logic [31:0] strut_bd,
    input  wire logic [31:0] strut_cd,
    input  wire logic        below,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      pos_x,
    output logic [31:0]      pos_y,
    output logic [31:0]      pos_z,
    output logic [1:0]       status
);

    logic [31:0] bx_reg, cx_reg, cy_reg;
    logic        adv;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic v8_reg, v9_reg, v10_reg, v11_reg, out_valid_reg;

    logic [31:0]        ad1_reg;
    logic               below1_reg;
    logic [63:0]        ad2_1_reg, bd2_1_reg, cd2_1_reg, bx2_1_reg, cx2_1_reg, cy2_1_reg;
    logic [31:0]        ad2s_reg;
    logic               below2_reg;
    logic [63:0]        ad2_2_reg;
    logic signed [66:0] n2_reg, mp2_reg;
    logic [tfk_pkg::NUM_W-1:0] nmag3_reg;
    logic               nneg3_reg;
    tfk_pkg::tfk_side_t side3_reg, side4_reg, side5_reg, side6_reg, side7_reg;
    tfk_pkg::tfk_side_t side8_reg, side9_reg, side10_reg, side11_reg;
    logic signed [65:0] prod5_reg;
    logic [tfk_pkg::NUM_W-1:0] mmag7_reg;
    logic               mneg7_reg;
    logic [31:0]        xm8_reg;
    logic [63:0]        xm2_9_reg, ym2_9_reg, ym2_10_reg, rest10_reg, rad11_reg;
    logic [31:0]        pos_x_reg, pos_y_reg, pos_z_reg;
    tfk_pkg::tfk_status_t status_reg;

    logic                      dx_valid, dy_valid, sq_valid;
    logic [31:0]               dx_quo, dy_quo, sq_root;
    logic                      dx_neg, dy_neg, dx_ovf, dy_ovf;
    tfk_pkg::tfk_side_t        dx_side, dy_side, sq_side;
    tfk_pkg::tfk_side_t        side3_next, side4_next, side8_next, side11_next;

    logic signed [66:0] n2_next, mp2_next;
    logic signed [32:0] xq, x4_next, k5;
    logic signed [65:0] prod5_next;
    logic signed [69:0] m6_next;
    logic [64:0]        diff11;
    logic signed [32:0] yo, zo;
    logic [31:0]        pos_x_next, pos_y_next, pos_z_next;
    tfk_pkg::tfk_status_t status_next;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bx_reg <= tfk_pkg::CFG_RESET;
            cx_reg <= tfk_pkg::CFG_RESET;
            cy_reg <= tfk_pkg::CFG_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tfk_pkg::CFG_BX: bx_reg <= cfg_data;
                tfk_pkg::CFG_CX: cx_reg <= cfg_data;
                tfk_pkg::CFG_CY: cy_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0;
            v9_reg <= 1'b0; v10_reg <= 1'b0; v11_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= dx_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= dy_valid;
            v9_reg <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
            out_valid_reg <= sq_valid;
        end
    end

    // The sphere differences for x and for the constant part of y.
    assign n2_next  = $signed({3'b000, ad2_1_reg}) + $signed({3'b000, bx2_1_reg})
                    - $signed({3'b000, bd2_1_reg});
    assign mp2_next = $signed({3'b000, bd2_1_reg}) - $signed({3'b000, cd2_1_reg})
                    + $signed({3'b000, cx2_1_reg}) + $signed({3'b000, cy2_1_reg})
                    - $signed({3'b000, bx2_1_reg});

    always_comb
    begin
        side3_next       = '0;
        side3_next.ad    = ad2s_reg;
        side3_next.below = below2_reg;
        side3_next.ad2   = ad2_2_reg;
        side3_next.mpart = mp2_reg;
    end

    assign xq      = $signed({1'b0, dx_quo});
    assign x4_next = (dx_neg ^ bx_reg[31]) ? -xq : xq;
    assign k5      = $signed({cx_reg[31], cx_reg}) - $signed({bx_reg[31], bx_reg});
    assign prod5_next = k5 * side5_reg.x;
    assign m6_next = 70'(side6_reg.mpart) - 70'($signed({prod5_reg, 1'b0}));
    assign diff11  = {1'b0, rest10_reg} - {1'b0, ym2_10_reg};

    always_comb
    begin
        side4_next      = dx_side;
        side4_next.x    = x4_next;
        side4_next.fail = dx_side.fail || dx_ovf || (dx_quo > dx_side.ad);
    end

    always_comb
    begin
        side8_next      = dy_side;
        side8_next.ym   = dy_quo;
        side8_next.yneg = dy_neg ^ cy_reg[31];
        side8_next.fail = dy_side.fail || dy_ovf || (dy_quo > dy_side.ad);
    end

    always_comb
    begin
        side11_next      = side10_reg;
        side11_next.fail = side10_reg.fail || diff11[64];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ad1_reg    <= strut_ad;
            below1_reg <= below;
            ad2_1_reg  <= strut_ad * strut_ad;
            bd2_1_reg  <= strut_bd * strut_bd;
            cd2_1_reg  <= strut_cd * strut_cd;
            bx2_1_reg  <= tfk_pkg::mag32(bx_reg) * tfk_pkg::mag32(bx_reg);
            cx2_1_reg  <= tfk_pkg::mag32(cx_reg) * tfk_pkg::mag32(cx_reg);
            cy2_1_reg  <= tfk_pkg::mag32(cy_reg) * tfk_pkg::mag32(cy_reg);

            ad2s_reg   <= ad1_reg;
            below2_reg <= below1_reg;
            ad2_2_reg  <= ad2_1_reg;
            n2_reg     <= n2_next;
            mp2_reg    <= mp2_next;

            nneg3_reg  <= n2_reg[66];
            nmag3_reg  <= {5'b00000, (n2_reg[66] ? 67'(-n2_reg) : 67'(n2_reg))};
            side3_reg  <= side3_next;

            side4_reg <= side4_next;

            side5_reg <= side4_reg;

            side6_reg <= side5_reg;
            prod5_reg <= prod5_next;

            side7_reg <= side6_reg;
            mneg7_reg <= m6_next[69];
            mmag7_reg <= {2'b00, (m6_next[69] ? 70'(-m6_next) : 70'(m6_next))};

            side8_reg      <= side8_next;
            xm8_reg        <= dy_side.x[32] ? 32'(-dy_side.x) : dy_side.x[31:0];

            side9_reg <= side8_reg;
            xm2_9_reg <= xm8_reg * xm8_reg;
            ym2_9_reg <= side8_reg.ym * side8_reg.ym;

            side10_reg <= side9_reg;
            rest10_reg <= side9_reg.ad2 - xm2_9_reg;
            ym2_10_reg <= ym2_9_reg;

            side11_reg      <= side11_next;
            rad11_reg       <= diff11[63:0];

            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            pos_z_reg  <= pos_z_next;
            status_reg <= status_next;
        end
    end

    tfk_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v3_reg),
        .in_num    (nmag3_reg),
        .in_neg    (nneg3_reg),
        .in_den    (tfk_pkg::abs2x(bx_reg)),
        .in_side   (side3_reg),
        .out_valid (dx_valid),
        .out_quo   (dx_quo),
        .out_neg   (dx_neg),
        .out_ovf   (dx_ovf),
        .out_side  (dx_side)
    );

    tfk_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v7_reg),
        .in_num    (mmag7_reg),
        .in_neg    (mneg7_reg),
        .in_den    (tfk_pkg::abs2x(cy_reg)),
        .in_side   (side7_reg),
        .out_valid (dy_valid),
        .out_quo   (dy_quo),
        .out_neg   (dy_neg),
        .out_ovf   (dy_ovf),
        .out_side  (dy_side)
    );

    tfk_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v11_reg),
        .in_rad    (rad11_reg),
        .in_side   (side11_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign yo = sq_side.yneg ? -$signed({1'b0, sq_side.ym}) : $signed({1'b0, sq_side.ym});
    assign zo = sq_side.below ? -$signed({1'b0, sq_root}) : $signed({1'b0, sq_root});

    always_comb
    begin
        priority if (bx_reg == 32'd0)
        begin
            status_next = tfk_pkg::ST_B_ORIGIN;
        end
        else if (cy_reg == 32'd0)
        begin
            status_next = tfk_pkg::ST_COLLINEAR;
        end
        else if (sq_side.fail)
        begin
            status_next = tfk_pkg::ST_UNREACH;
        end
        else
        begin
            status_next = tfk_pkg::ST_OK;
        end
    end

    always_comb
    begin
        if (status_next == tfk_pkg::ST_OK)
        begin
            pos_x_next = tfk_pkg::sat33(sq_side.x);
            pos_y_next = tfk_pkg::sat33(yo);
            pos_z_next = tfk_pkg::sat33(zo);
        end
        else
        begin
            pos_x_next = 32'd0;
            pos_y_next = 32'd0;
            pos_z_next = 32'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign status    = status_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != tfk_pkg::ST_OK)
        |-> (pos_x_reg == 32'd0) && (pos_y_reg == 32'd0) && (pos_z_reg == 32'd0))
        else $error("error result carries nonzero coordinates");

    a_take_first: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v1_reg)
        else $error("accepted beat missing from first stage");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v1_reg) && $stable(v11_reg))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// File: test/tripod_forward_kinematics_tb.sv
// Self-checking testbench for the tripod trilateration pipeline, directed and random.
`default_nettype none

module tripod_forward_kinematics_tb;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        tfk_pkg::tfk_status_t st;
    } point_t;

    typedef struct {
        logic [31:0] ad;
        logic [31:0] bd;
        logic [31:0] cd;
        logic        blw;
        bit          typed;
        point_t      res;
    } row_t;

    typedef logic signed [129:0] big_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] strut_ad;
    logic [31:0] strut_bd;
    logic [31:0] strut_cd;
    logic        below;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [1:0]  status;

    logic [31:0] base_bx_q;
    logic [31:0] base_cx_q;
    logic [31:0] base_cy_q;
    point_t      pending_points[$];
    row_t        dir_rows[0:7];
    int          mismatches;
    int          burst_left;
    int          idle_cycles;
    longint      cycle_count;
    bit          hold_req;

    tripod_forward_kinematics uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .strut_ad  (strut_ad),
        .strut_bd  (strut_bd),
        .strut_cd  (strut_cd),
        .below     (below),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic logic [127:0] root_floor(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] b;
        logic [127:0] vv;
        r  = '0;
        vv = v;
        b  = 128'd1 << 126;
        while (b > vv)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (vv >= r + b)
            begin
                vv = vv - (r + b);
                r  = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit div_bounded(input big_t n, input big_t d, input big_t lim,
                                       output big_t q);
        big_t m;
        m = (n < 0) ? -n : n;
        q = '0;
        if (m >= (lim + 1) * d)
        begin
            return 1'b0;
        end
        q = m / d;
        if (n < 0)
        begin
            q = -q;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] clamp32(input big_t v);
        if (v > big_t'(64'sd2147483647))
        begin
            return 32'h7FFF_FFFF;
        end
        if (v < -big_t'(64'sd2147483648))
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic point_t locate_tool(input logic [31:0] ad, input logic [31:0] bd,
                                           input logic [31:0] cd, input logic blw);
        big_t   sad;
        big_t   sbd;
        big_t   scd;
        big_t   sbx;
        big_t   scx;
        big_t   scy;
        big_t   num;
        big_t   den;
        big_t   xq;
        big_t   yq;
        big_t   zq;
        big_t   rest;
        point_t p;
        sad  = {98'd0, ad};
        sbd  = {98'd0, bd};
        scd  = {98'd0, cd};
        sbx  = {{98{base_bx_q[31]}}, base_bx_q};
        scx  = {{98{base_cx_q[31]}}, base_cx_q};
        scy  = {{98{base_cy_q[31]}}, base_cy_q};
        xq   = '0;
        yq   = '0;
        zq   = '0;
        p.st = tfk_pkg::ST_OK;
        if (sbx == 0)
        begin
            p.st = tfk_pkg::ST_B_ORIGIN;
        end
        else if (scy == 0)
        begin
            p.st = tfk_pkg::ST_COLLINEAR;
        end
        else
        begin
            num = sad * sad + sbx * sbx - sbd * sbd;
            den = (sbx < 0) ? -sbx : sbx;
            if (!div_bounded(num, den + den, sad, xq))
            begin
                p.st = tfk_pkg::ST_UNREACH;
            end
            else
            begin
                if (sbx < 0)
                begin
                    xq = -xq;
                end
                num = sbd * sbd - scd * scd + scx * scx + scy * scy - sbx * sbx
                      - (scx - sbx) * xq * 2;
                den = (scy < 0) ? -scy : scy;
                if (!div_bounded(num, den + den, sad, yq))
                begin
                    p.st = tfk_pkg::ST_UNREACH;
                end
                else
                begin
                    if (scy < 0)
                    begin
                        yq = -yq;
                    end
                    rest = sad * sad - xq * xq;
                    if (yq * yq > rest)
                    begin
                        p.st = tfk_pkg::ST_UNREACH;
                    end
                    else
                    begin
                        zq = {2'b00, root_floor(128'(rest - yq * yq))};
                        if (blw)
                        begin
                            zq = -zq;
                        end
                    end
                end
            end
        end
        if (p.st != tfk_pkg::ST_OK)
        begin
            xq = '0;
            yq = '0;
            zq = '0;
        end
        p.x = clamp32(xq);
        p.y = clamp32(yq);
        p.z = clamp32(zq);
        return p;
    endfunction

    task automatic write_base(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            tfk_pkg::CFG_BX: base_bx_q = val;
            tfk_pkg::CFG_CX: base_cx_q = val;
            default: base_cy_q = val;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic offer_struts(input logic [31:0] ad, input logic [31:0] bd,
                                input logic [31:0] cd, input logic blw, input point_t exp_p);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left = burst_left - 1;
        in_valid <= 1'b1;
        strut_ad <= ad;
        strut_bd <= bd;
        strut_cd <= cd;
        below    <= blw;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pending_points.push_back(exp_p);
    endtask

    task automatic drain_pipeline();
        if (in_valid)
        begin
            in_valid <= 1'b0;
        end
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (120) @(posedge clk);
    endtask

    task automatic run_points(input int count, input bit typed_err,
                              input tfk_pkg::tfk_status_t err);
        logic [31:0]  ad;
        logic [31:0]  bd;
        logic [31:0]  cd;
        logic         blw;
        big_t         dx;
        big_t         dy;
        big_t         dz;
        big_t         sbx;
        big_t         scx;
        big_t         scy;
        logic [127:0] len;
        point_t       p;
        sbx = {{98{base_bx_q[31]}}, base_bx_q};
        scx = {{98{base_cx_q[31]}}, base_cx_q};
        scy = {{98{base_cy_q[31]}}, base_cy_q};
        for (int i = 0; i < count; i++)
        begin
            blw = $urandom_range(0, 1);
            if ($urandom_range(0, 9) < 7)
            begin
                dx  = $signed(32'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
                dy  = $signed(32'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
                dz  = $signed(32'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
                len = root_floor(128'(dx * dx + dy * dy + dz * dz));
                ad  = len[31:0];
                len = root_floor(128'((dx - sbx) * (dx - sbx) + dy * dy + dz * dz));
                bd  = len[31:0];
                len = root_floor(128'((dx - scx) * (dx - scx) + (dy - scy) * (dy - scy)
                                      + dz * dz));
                cd  = len[31:0];
            end
            else
            begin
                ad = $urandom;
                bd = $urandom;
                cd = $urandom;
            end
            if (typed_err)
            begin
                p = '{x: 32'd0, y: 32'd0, z: 32'd0, st: err};
            end
            else
            begin
                p = locate_tool(ad, bd, cd, blw);
            end
            offer_struts(ad, bd, cd, blw, p);
        end
    endtask

    task automatic random_bases();
        logic [31:0] v;
        v = $urandom_range(1, 32'h0020_0000);
        write_base(tfk_pkg::CFG_BX, $urandom_range(0, 1) ? v : -v);
        v = $urandom_range(0, 32'h0020_0000);
        write_base(tfk_pkg::CFG_CX, $urandom_range(0, 1) ? v : -v);
        v = $urandom_range(1, 32'h0020_0000);
        write_base(tfk_pkg::CFG_CY, $urandom_range(0, 1) ? v : -v);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = tfk_pkg::CFG_BX;
        cfg_data    = '0;
        in_valid    = 1'b0;
        strut_ad    = '0;
        strut_bd    = '0;
        strut_cd    = '0;
        below       = 1'b0;
        base_bx_q   = tfk_pkg::CFG_RESET;
        base_cx_q   = tfk_pkg::CFG_RESET;
        base_cy_q   = tfk_pkg::CFG_RESET;
        mismatches  = 0;
        burst_left  = 0;
        hold_req    = 1'b0;
        dir_rows[0] = '{32'd0, 32'd0, 32'd0, 1'b0, 1'b1,
                        '{32'd0, 32'd0, 32'd0, tfk_pkg::ST_UNREACH}};
        dir_rows[1] = '{32'h0001_0000, 32'd0, 32'h0001_0000, 1'b0, 1'b1,
                        '{32'h0001_0000, 32'd0, 32'd0, tfk_pkg::ST_OK}};
        dir_rows[2] = '{32'h0001_0000, 32'd0, 32'h0001_0000, 1'b1, 1'b1,
                        '{32'h0001_0000, 32'd0, 32'd0, tfk_pkg::ST_OK}};
        dir_rows[3] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, '0};
        dir_rows[4] = '{32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0, 1'b0, '0};
        dir_rows[5] = '{32'h0001_0000, 32'h0001_6A0A, 32'h0001_6A0A, 1'b0, 1'b0, '0};
        dir_rows[6] = '{32'h0000_0000, 32'h0001_0000, 32'h0001_6A0A, 1'b1, 1'b0, '0};
        dir_rows[7] = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, '0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The receiver holds off while the first rows stream in, so the pipeline fills.
        hold_req = 1'b1;
        foreach (dir_rows[i])
        begin
            offer_struts(dir_rows[i].ad, dir_rows[i].bd, dir_rows[i].cd, dir_rows[i].blw,
                         dir_rows[i].typed ? dir_rows[i].res
                         : locate_tool(dir_rows[i].ad, dir_rows[i].bd, dir_rows[i].cd,
                                       dir_rows[i].blw));
        end
        run_points(150, 1'b0, tfk_pkg::ST_OK);
        drain_pipeline();

        write_base(tfk_pkg::CFG_BX, 32'd0);
        write_base(tfk_pkg::CFG_CY, 32'd0);
        run_points(25, 1'b1, tfk_pkg::ST_B_ORIGIN);
        drain_pipeline();

        write_base(tfk_pkg::CFG_BX, 32'hFFFF_0000);
        run_points(25, 1'b1, tfk_pkg::ST_COLLINEAR);
        drain_pipeline();

        write_base(tfk_pkg::CFG_BX, 32'h8000_0000);
        write_base(tfk_pkg::CFG_CX, 32'h7FFF_FFFF);
        write_base(tfk_pkg::CFG_CY, 32'h8000_0000);
        run_points(100, 1'b0, tfk_pkg::ST_OK);
        drain_pipeline();

        write_base(tfk_pkg::CFG_BX, 32'h7FFF_FFFF);
        write_base(tfk_pkg::CFG_CX, 32'h8000_0000);
        write_base(tfk_pkg::CFG_CY, 32'h7FFF_FFFF);
        run_points(100, 1'b0, tfk_pkg::ST_OK);
        drain_pipeline();

        write_base(tfk_pkg::CFG_BX, 32'd1);
        write_base(tfk_pkg::CFG_CX, 32'd0);
        write_base(tfk_pkg::CFG_CY, 32'hFFFF_FFFF);
        run_points(60, 1'b0, tfk_pkg::ST_OK);
        drain_pipeline();

        for (int ph = 0; ph < 6; ph++)
        begin
            random_bases();
            run_points(130, 1'b0, tfk_pkg::ST_OK);
            drain_pipeline();
        end

        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // The receiver switches at random among four stall patterns, with one long hold-off.
    initial
    begin
        int mode;
        bit held;
        out_ready   = 1'b0;
        cycle_count = 0;
        mode        = 0;
        held        = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
            if (hold_req && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (500) @(posedge clk);
                cycle_count = cycle_count + 500;
            end
            if (cycle_count % 64 == 0)
            begin
                mode = $urandom_range(0, 3);
            end
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (cycle_count % 8 < 5);
            endcase
        end
    end

    always @(posedge clk)
    begin
        point_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_points.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                begin
                    $display("Unexpected result beat: x=%h y=%h z=%h status=%0d",
                             pos_x, pos_y, pos_z, status);
                end
            end
            else
            begin
                e = pending_points.pop_front();
                if (pos_x !== e.x || pos_y !== e.y || pos_z !== e.z
                    || status !== 2'(e.st))
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch: expected x=%h y=%h z=%h status=%0d,",
                                 e.x, e.y, e.z, e.st);
                        $display("          got x=%h y=%h z=%h status=%0d",
                                 pos_x, pos_y, pos_z, status);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= 3000)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire
